// ===== rtl/frdf_pkg.sv =====
// Shared types and codes for the FastCGI record deframer.
package frdf_pkg;

   localparam int HDR_LAST = 7;  // index of the final header byte

   // Result status codes
   localparam logic [1:0] STATUS_CONTENT = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_TERMINATED = 2'd2;

   // Configuration register indexes
   localparam logic CSR_EXPECTED_TYPE = 1'b0;
   localparam logic CSR_EXPECTED_REQUEST_ID = 1'b1;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_CONTENT = 4'b0010,
      PH_PAD = 4'b0100,
      PH_HALT = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic start_req;
   } req_type;

   typedef struct packed {
      logic [7:0] content_byte;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic valid;
      rsp_type data;
   } result_type;

endpackage

// ===== rtl/frdf_parser.sv =====
// Record parser: header gathering, check, content pass-through and padding skip.
module frdf_parser
   import frdf_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic accept,
   input req_type req,
   input logic [7:0] expected_type,
   input logic [15:0] expected_request_id,
   output result_type result
);

   phase_type phase_ff, phase_in, phase_eff;
   logic [2:0] header_count_ff, header_count_in, header_count_eff;
   logic [7:0] seen_type_ff, seen_type_in, seen_type_eff;
   logic [15:0] seen_id_ff, seen_id_in, seen_id_eff;
   logic [15:0] body_length_ff, body_length_in, body_length_eff;
   logic [7:0] pad_length_ff, pad_length_in, pad_length_eff;
   logic [15:0] body_count_ff, body_count_in, body_count_eff, body_count_inc;
   logic [7:0] pad_count_ff, pad_count_in, pad_count_eff, pad_count_inc;

   always_comb begin
      // a start beat clears the frame before this byte is taken
      phase_eff = req.start_req ? PH_HEADER : phase_ff;
      header_count_eff = req.start_req ? 3'd0 : header_count_ff;
      seen_type_eff = req.start_req ? 8'd0 : seen_type_ff;
      seen_id_eff = req.start_req ? 16'd0 : seen_id_ff;
      body_length_eff = req.start_req ? 16'd0 : body_length_ff;
      pad_length_eff = req.start_req ? 8'd0 : pad_length_ff;
      body_count_eff = req.start_req ? 16'd0 : body_count_ff;
      pad_count_eff = req.start_req ? 8'd0 : pad_count_ff;
      body_count_inc = body_count_eff + 16'd1;
      pad_count_inc = pad_count_eff + 8'd1;

      phase_in = phase_eff;
      header_count_in = header_count_eff;
      seen_type_in = seen_type_eff;
      seen_id_in = seen_id_eff;
      body_length_in = body_length_eff;
      pad_length_in = pad_length_eff;
      body_count_in = body_count_eff;
      pad_count_in = pad_count_eff;
      result = '0;

      case (phase_eff)
         PH_HEADER: begin
            header_count_in = header_count_eff + 3'd1;
            case (header_count_eff)
               3'd1: seen_type_in = req.data_byte;
               3'd2: seen_id_in = {req.data_byte, seen_id_eff[7:0]};
               3'd3: seen_id_in = {seen_id_eff[15:8], req.data_byte};
               3'd4: body_length_in = {req.data_byte, body_length_eff[7:0]};
               3'd5: body_length_in = {body_length_eff[15:8], req.data_byte};
               3'd6: pad_length_in = req.data_byte;
               default: ;
            endcase
            if (header_count_eff == 3'(HDR_LAST)) begin
               if (seen_type_eff != expected_type || seen_id_eff != expected_request_id) begin
                  phase_in = PH_HALT;
                  result.valid = 1'b1;
                  result.data.status = STATUS_MISMATCH;
               end else if (body_length_eff == 16'd0) begin
                  phase_in = PH_HALT;
                  result.valid = 1'b1;
                  result.data.status = STATUS_TERMINATED;
               end else begin
                  body_count_in = 16'd0;
                  pad_count_in = 8'd0;
                  phase_in = PH_CONTENT;
               end
            end
         end
         PH_CONTENT: begin
            result.valid = 1'b1;
            result.data.content_byte = req.data_byte;
            result.data.status = STATUS_CONTENT;
            body_count_in = body_count_inc;
            if (body_count_inc == body_length_eff) begin
               body_count_in = 16'd0;
               pad_count_in = 8'd0;
               phase_in = (pad_length_eff == 8'd0) ? PH_HEADER : PH_PAD;
            end
         end
         PH_PAD: begin
            pad_count_in = pad_count_inc;
            if (pad_count_inc >= pad_length_eff) begin
               pad_count_in = 8'd0;
               phase_in = PH_HEADER;
            end
         end
         default: ;  // halted: wait for a start beat
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         header_count_ff <= 3'd0;
         seen_type_ff <= 8'd0;
         seen_id_ff <= 16'd0;
         body_length_ff <= 16'd0;
         pad_length_ff <= 8'd0;
         body_count_ff <= 16'd0;
         pad_count_ff <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         header_count_ff <= header_count_in;
         seen_type_ff <= seen_type_in;
         seen_id_ff <= seen_id_in;
         body_length_ff <= body_length_in;
         pad_length_ff <= pad_length_in;
         body_count_ff <= body_count_in;
         pad_count_ff <= pad_count_in;
      end
   end

endmodule

// ===== rtl/fastcgi_record_deframer_top.sv =====
// Top level of the FastCGI record deframer: config registers, parser, result register.
//
//   channel | dir | ports                        | beat
//   --------+-----+------------------------------+---------------------------------
//   req     | in  | req_valid req_stall req_data | one stream byte + start flag
//   rsp     | out | rsp_valid rsp_stall rsp_data | content byte or status
//   csr     | in  | csr_we csr_index csr_wdata   | register write, no read-back
//
// One byte per cycle while the input side is not stalled. The parser updates
// its frame state from the byte in the accepting cycle; a result, if any,
// appears in the result register the cycle after. Only a full, stalled result
// register stalls the input side, so the next byte is taken while a result is
// being handed off. Reset is synchronous and puts the parser in header phase;
// expected type resets to 0, expected request id to 1.
module fastcgi_record_deframer_top
   import frdf_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data,
   input logic csr_we,
   input logic csr_index,
   input logic [15:0] csr_wdata
);

   logic [7:0] expected_type_ff;
   logic [15:0] expected_request_id_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic req_accept;
   logic rsp_free;
   result_type result;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_type_ff <= 8'd0;
         expected_request_id_ff <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EXPECTED_TYPE: expected_type_ff <= csr_wdata[7:0];
            CSR_EXPECTED_REQUEST_ID: expected_request_id_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // result slot is free when empty or being taken this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !rsp_free;
   assign req_accept = req_valid && rsp_free;

   frdf_parser u_parser (
      .clock(clock),
      .reset(reset),
      .accept(req_accept),
      .req(req_data),
      .expected_type(expected_type_ff),
      .expected_request_id(expected_request_id_ff),
      .result(result)
   );

   assign rsp_valid_in = req_accept && result.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free && rsp_valid_in) begin
         rsp_data_ff <= result.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the FastCGI record deframer: directed and random byte streams.
`timescale 1ns / 100ps

module tb_top;
   import frdf_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200_000;
   localparam int SETTLE_CYCLES = 4;     // result register plus margin
   localparam int PRINT_LIMIT = 100;     // keep the log readable on a bad run

   // ---------------------------------------------------------------- DUT I/O
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   fastcgi_record_deframer_top i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------- deframer shadow state
   // Register copies, at their reset values.
   logic [7:0] cfg_type = 8'h00;
   logic [15:0] cfg_id = 16'h0001;

   // Frame state, mirrors the parser after reset.
   phase_type parse_phase = PH_HEADER;
   logic [3:0] hdr_count = '0;
   logic [7:0] seen_type = '0;
   logic [15:0] seen_id = '0;
   logic [15:0] body_len = '0;
   logic [7:0] pad_len = '0;
   logic [15:0] body_count = '0;
   logic [7:0] pad_count = '0;

   rsp_type deframed_q[$];   // results owed by the block, oldest first
   rsp_type head_rsp;
   int error_count = 0;
   int live_bytes = 0;       // beats that the parser actually acts on
   int unsigned cycle_count = 0;
   bit quiet = 1'b0;         // set: neither side idles

   // Advance the shadow parser by one accepted beat; queue any result it owes.
   function automatic void deframe_byte(input logic [7:0] b, input logic s);
      rsp_type r;
      r.content_byte = 8'h00;
      r.status = STATUS_CONTENT;
      if (s) begin
         // start beat wipes the frame, then is parsed as header byte 0
         parse_phase = PH_HEADER;
         hdr_count = '0;
         seen_type = '0;
         seen_id = '0;
         body_len = '0;
         pad_len = '0;
         body_count = '0;
         pad_count = '0;
      end
      case (parse_phase)
         PH_HEADER: begin
            // byte 0 is the version and byte 7 reserved: neither is checked
            case (hdr_count)
               4'd1: seen_type = b;
               4'd2: seen_id[15:8] = b;
               4'd3: seen_id[7:0] = b;
               4'd4: body_len[15:8] = b;
               4'd5: body_len[7:0] = b;
               4'd6: pad_len = b;
               default: ;
            endcase
            if (hdr_count == 4'(HDR_LAST)) begin
               // header is judged on its last byte; a fault wins over a zero length
               hdr_count = '0;
               if (seen_type != cfg_type || seen_id != cfg_id) begin
                  parse_phase = PH_HALT;
                  r.status = STATUS_MISMATCH;
                  deframed_q.push_back(r);
               end else if (body_len == 16'd0) begin
                  parse_phase = PH_HALT;
                  r.status = STATUS_TERMINATED;
                  deframed_q.push_back(r);
               end else begin
                  body_count = '0;
                  pad_count = '0;
                  parse_phase = PH_CONTENT;
               end
            end else begin
               hdr_count++;
            end
         end
         PH_CONTENT: begin
            body_count++;
            if (body_count == body_len) begin
               body_count = '0;
               pad_count = '0;
               parse_phase = (pad_len == 8'd0) ? PH_HEADER : PH_PAD;
            end
            r.content_byte = b;
            deframed_q.push_back(r);
         end
         PH_PAD: begin
            pad_count++;
            if (pad_count >= pad_len) begin
               pad_count = '0;
               parse_phase = PH_HEADER;
            end
         end
         default: ;  // halted: wait for a start beat
      endcase
   endfunction

   // --------------------------------------------------------------- helpers
   function automatic bit take_break();
      return !quiet && ($urandom_range(99) < 9);
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   // Drive one beat, hold it until taken, then update the shadow parser.
   // Valid stays high on return so back-to-back beats need no second drive.
   task automatic send_byte(input logic [7:0] b, input logic s);
      while (take_break()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data <= {b, s};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (s || parse_phase != PH_HALT)
         live_bytes++;
      deframe_byte(b, s);
   endtask

   // Header plus random content and padding; keep cuts the record short.
   task automatic send_record(input logic [7:0] typ, input logic [15:0] id,
                              input logic [15:0] len, input logic [7:0] pad,
                              input bit restart, input int keep);
      logic [7:0] hdr [8];
      int total;
      hdr[0] = 8'($urandom);
      hdr[1] = typ;
      hdr[2] = id[15:8];
      hdr[3] = id[7:0];
      hdr[4] = len[15:8];
      hdr[5] = len[7:0];
      hdr[6] = pad;
      hdr[7] = 8'($urandom);
      total = 8 + int'(len) + int'(pad);
      for (int i = 0; i < total && i < keep; i++)
         send_byte((i < 8) ? hdr[i] : 8'($urandom), restart && i == 0);
   endtask

   // Drop valid, wait for every owed result, then let the pipe settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (deframed_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_EXPECTED_TYPE)
         cfg_type = val[7:0];
      else
         cfg_id = val;
      @(posedge clock);
   endtask

   // ----------------------------------------------------------------- tests
   // Registers at reset values, no start beat: one record with padding,
   // extreme content bytes, then a terminator and a beat that must be ignored.
   task automatic test_after_reset();
      send_record(8'h00, 16'h0001, 16'd2, 8'd1, 1'b0, 8);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);   // padding, no result
      send_record(8'h00, 16'h0001, 16'd0, 8'd0, 1'b0, 8);
      send_byte(8'h3C, 1'b0);   // halted
   endtask

   // Upper registers extremes. Zero padding runs straight into a header whose
   // low id byte is wrong; then a start with a bad type and zero length.
   task automatic test_header_faults();
      wait_idle();
      write_csr(CSR_EXPECTED_TYPE, 16'hA5FF);   // upper byte must be dropped
      write_csr(CSR_EXPECTED_REQUEST_ID, 16'hFFFF);
      send_record(8'hFF, 16'hFFFF, 16'd1, 8'd0, 1'b1, 9);
      send_record(8'hFF, 16'hFF00, 16'd2, 8'd0, 1'b0, 8);
      send_record(8'h00, 16'hFFFF, 16'd0, 8'd0, 1'b1, 8);
   endtask

   // Lower register extremes. Start beats in the middle of content and of a
   // header both restart the frame.
   task automatic test_restart();
      wait_idle();
      write_csr(CSR_EXPECTED_TYPE, 16'h0000);
      write_csr(CSR_EXPECTED_REQUEST_ID, 16'h0000);
      send_record(8'h00, 16'h0000, 16'd3, 8'd0, 1'b1, 9);
      send_record(8'h00, 16'h0000, 16'd0, 8'd0, 1'b1, 4);
      send_record(8'h00, 16'h0000, 16'd0, 8'd0, 1'b1, 8);
   endtask

   // Mostly well-formed records under a fresh register setting; a share of
   // bad headers, terminators, cut records, stray restarts and noise beats.
   task automatic test_random_traffic(input int target, input bit no_idle);
      int first;
      int pick;
      int total;
      int keep;
      bit restart;
      logic [7:0] typ;
      logic [15:0] id;
      logic [15:0] len;
      logic [7:0] pad;
      wait_idle();
      write_csr(CSR_EXPECTED_TYPE, 16'($urandom));
      write_csr(CSR_EXPECTED_REQUEST_ID, 16'($urandom));
      quiet = no_idle;
      first = live_bytes;
      while (live_bytes - first < target) begin
         // junk while halted is dropped by the block
         if (parse_phase == PH_HALT && $urandom_range(99) < 30)
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0);
         restart = (parse_phase == PH_HALT) || ($urandom_range(99) < 6);
         pick = $urandom_range(99);
         if (pick < 5) begin
            send_byte(8'($urandom), 1'($urandom));
         end else begin
            typ = (pick < 12) ? 8'($urandom) : cfg_type;
            id = (pick >= 12 && pick < 19) ? 16'($urandom) : cfg_id;
            pick = $urandom_range(99);
            if (pick < 8)
               len = 16'd0;
            else if (pick < 10)
               len = 16'($urandom_range(320, 256));
            else if (pick < 25)
               len = 16'($urandom_range(40, 13));
            else
               len = 16'($urandom_range(12, 1));
            pick = $urandom_range(99);
            if (pick < 40)
               pad = 8'd0;
            else if (pick < 97)
               pad = 8'($urandom_range(7, 1));
            else
               pad = 8'($urandom_range(255, 200));
            total = 8 + int'(len) + int'(pad);
            keep = ($urandom_range(99) < 5) ? $urandom_range(total - 1, 1) : total;
            send_record(typ, id, len, pad, restart, keep);
         end
      end
      quiet = 1'b0;
   endtask

   // --------------------------------------------------------- result checker
   // Samples at the edge, then picks the next stall value for the sink side.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (deframed_q.size() == 0) begin
            report_error($sformatf("unexpected beat: status %0d byte %02h",
                                   rsp_data.status, rsp_data.content_byte));
         end else begin
            head_rsp = deframed_q.pop_front();
            if (rsp_data.status !== head_rsp.status)
               report_error($sformatf("status %0d, want %0d",
                                      rsp_data.status, head_rsp.status));
            if (rsp_data.content_byte !== head_rsp.content_byte)
               report_error($sformatf("content byte %02h, want %02h",
                                      rsp_data.content_byte, head_rsp.content_byte));
         end
      end
      rsp_stall <= take_break();
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // ------------------------------------------------------------------ main
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_after_reset();
      test_header_faults();
      test_restart();
      test_random_traffic(280, 1'b0);
      test_random_traffic(280, 1'b1);   // no idling either side
      test_random_traffic(280, 1'b0);
      test_random_traffic(280, 1'b0);
      wait_idle();
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
